// ===== hdl/red_pkg.sv =====
`default_nettype none

package red_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int RECT_W     = 15;
  localparam int ENV_W      = 23;
  localparam int COEF_W     = 17;
  localparam int FACTOR_W   = 7;
  localparam int OFFSET_W   = 16;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;
  localparam int FP_W       = 22;            // factor * previous rectified sample
  localparam int DIFF_W     = 25;            // factor * prev - envelope, signed
  localparam int MAG_W      = 23;            // magnitude of the difference
  localparam int HI_W       = MAG_W + 1;     // accumulator half of the multiplier
  localparam int PROD_W     = MAG_W + COEF_W;
  localparam int QUO_W      = 24;            // quotient bits of the divider
  localparam int UPD_W      = 26;            // envelope update before saturation
  localparam int MAX_CHANNELS = 2;

  localparam int MUL_STEPS = COEF_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Arithmetic constants
  localparam logic [COEF_W-1:0] COEF_SCALE = COEF_W'(100000);
  localparam int ENV_MAX = 4194303;
  localparam int ENV_MIN = -4194304;
  localparam int SAT_MAX = 32767;

  // Register reset values
  localparam logic                RST_RECTIFY = 1'b1;
  localparam logic [PERIOD_W-1:0] RST_PERIOD  = PERIOD_W'(1);
  localparam logic [COEF_W-1:0]   RST_COEF    = '0;
  localparam logic [FACTOR_W-1:0] RST_FACTOR  = FACTOR_W'(1);
  localparam logic [OFFSET_W-1:0] RST_OFFSET  = OFFSET_W'(100);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECTIFY_ENABLE    = 4'd0,
    REG_DECIMATION_PERIOD = 4'd1,
    REG_COEF_A            = 4'd2,
    REG_COEF_B            = 4'd3,
    REG_FACTOR_A          = 4'd4,
    REG_FACTOR_B          = 4'd5,
    REG_OFFSET_A          = 4'd6,
    REG_OFFSET_B          = 4'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MLOAD,
    S_MUL,
    S_FLOAD,
    S_FDIV,
    S_UPD,
    S_OLOAD,
    S_ODIV,
    S_OFIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic restart;
    logic capture;
    logic prep;
    logic mload;
    logic mstep;
    logic fload;
    logic oload;
    logic dstep;
    logic upd;
    logic ofin;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/red_if.sv =====
`default_nettype none

interface red_in_if import red_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    command;
  sample_t sample_a;
  sample_t sample_b;

  modport source (output valid, command, sample_a, sample_b, input ready);
  modport sink   (input valid, command, sample_a, sample_b, output ready);
endinterface

interface red_out_if import red_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t value_a;
  sample_t value_b;

  modport source (output valid, value_a, value_b, input ready);
  modport sink   (input valid, value_a, value_b, output ready);
endinterface

interface red_cfg_if import red_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/red_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per step. rem0 must be below den.
module red_div import red_pkg::*; (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              step,
  input  wire logic [COEF_W-1:0] rem0,
  input  wire logic [COEF_W-1:0] den,
  input  wire logic [QUO_W-1:0]  num,
  output logic      [QUO_W-1:0]  quo
);

  logic [COEF_W-1:0] rem_r, rem_nxt;
  logic [COEF_W-1:0] den_r;
  logic [QUO_W-1:0]  sh_r, sh_nxt;
  logic [COEF_W:0]   shifted;
  logic [COEF_W+1:0] trial;

  always_comb begin
    shifted = {rem_r, sh_r[QUO_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    if (!trial[COEF_W+1]) begin
      rem_nxt = trial[COEF_W-1:0];
      sh_nxt  = {sh_r[QUO_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[COEF_W-1:0];
      sh_nxt  = {sh_r[QUO_W-2:0], 1'b0};
    end
  end

  // Hold the divisor for the whole division
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem0;
      den_r <= den;
      sh_r  <= num;
    end else if (step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign quo = sh_r;

endmodule

`default_nettype wire

// ===== hdl/red_lane.sv =====
`default_nettype none

// One channel: rectifier, serial multiplier, envelope update and output scaling.
module red_lane import red_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic                rect_en,
  input  wire logic [COEF_W-1:0]   coef,
  input  wire logic [FACTOR_W-1:0] factor,
  input  wire logic [OFFSET_W-1:0] offset,
  input  wire sample_t             sample,
  output sample_t                  value
);

  localparam logic signed [UPD_W-1:0] E_MAX = UPD_W'(ENV_MAX);
  localparam logic signed [UPD_W-1:0] E_MIN = UPD_W'(ENV_MIN);
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  sample_t                  raw_r;
  logic [RECT_W-1:0]        prev_r;
  logic signed [ENV_W-1:0]  env_r, env_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt, diff_abs;
  logic [MAG_W-1:0]         mcand_r;
  logic                     neg_r;
  logic [HI_W-1:0]          hi_r;
  logic [COEF_W-1:0]        lo_r;
  logic [SAMPLE_W-1:0]      res_r, res_nxt;

  logic [FACTOR_W-1:0]      f_eff;
  sample_t                  neg_raw;
  logic [RECT_W-1:0]        rect_val;
  logic [FP_W-1:0]          fp;
  logic [HI_W:0]            msum;
  logic [COEF_W-1:0]        d_rem0, d_den;
  logic [QUO_W-1:0]         d_num, quo;
  logic signed [UPD_W-1:0]  upd_q, upd_sum;
  logic [RECT_W-1:0]        sat;
  logic [SAMPLE_W-1:0]      v16;

  assign f_eff   = (factor == '0) ? FACTOR_W'(1) : factor;
  assign neg_raw = -raw_r;

  // Absolute value, most negative code clamps to full scale
  always_comb begin
    if (!raw_r[SAMPLE_W-1]) begin
      rect_val = raw_r[RECT_W-1:0];
    end else if (raw_r == SAMPLE_MIN) begin
      rect_val = '1;
    end else begin
      rect_val = neg_raw[RECT_W-1:0];
    end
  end

  assign fp       = FP_W'(f_eff) * FP_W'(prev_r);
  assign diff_nxt = signed'({{(DIFF_W-FP_W){1'b0}}, fp}) - DIFF_W'(env_r);
  assign diff_abs = diff_r[DIFF_W-1] ? -diff_r : diff_r;

  // Shift-add step, one coefficient bit per cycle
  assign msum = {1'b0, hi_r} + (lo_r[0] ? (HI_W+1)'(mcand_r) : '0);

  // Divider feed: product by the coefficient scale, or envelope by the factor
  always_comb begin
    if (ctrl.oload) begin
      d_rem0 = '0;
      d_den  = COEF_W'(f_eff);
      d_num  = env_r[ENV_W-1] ? '0 : QUO_W'(env_r[ENV_W-2:0]);
    end else begin
      d_rem0 = COEF_W'(hi_r[PROD_W-COEF_W-1:QUO_W-COEF_W]);
      d_den  = COEF_SCALE;
      d_num  = {hi_r[QUO_W-COEF_W-1:0], lo_r};
    end
  end

  red_div u_div (
    .clk  (clk),
    .load (ctrl.fload | ctrl.oload),
    .step (ctrl.dstep),
    .rem0 (d_rem0),
    .den  (d_den),
    .num  (d_num),
    .quo  (quo)
  );

  // Envelope update with saturation
  always_comb begin
    upd_q   = signed'({{(UPD_W-QUO_W){1'b0}}, quo});
    upd_sum = UPD_W'(env_r) + (neg_r ? -upd_q : upd_q);
    if (upd_sum > E_MAX) begin
      env_nxt = E_MAX[ENV_W-1:0];
    end else if (upd_sum < E_MIN) begin
      env_nxt = E_MIN[ENV_W-1:0];
    end else begin
      env_nxt = upd_sum[ENV_W-1:0];
    end
  end

  // Output scaling: clamp, then drop the offset if the value exceeds it
  always_comb begin
    sat     = (quo > QUO_W'(SAT_MAX)) ? RECT_W'(SAT_MAX) : quo[RECT_W-1:0];
    v16     = {1'b0, sat};
    res_nxt = (v16 > offset) ? v16 - offset : v16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      env_r  <= '0;
    end else begin
      if (ctrl.restart) begin
        prev_r <= '0;
      end else if (ctrl.prep) begin
        prev_r <= rect_val;
      end
      if (ctrl.upd) begin
        env_r <= env_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      raw_r <= sample;
    end
    if (ctrl.prep) begin
      diff_r <= diff_nxt;
    end
    if (ctrl.mload) begin
      mcand_r <= diff_abs[MAG_W-1:0];
      neg_r   <= diff_r[DIFF_W-1];
      hi_r    <= '0;
      lo_r    <= coef;
    end else if (ctrl.mstep) begin
      hi_r <= msum[HI_W:1];
      lo_r <= {msum[0], lo_r[COEF_W-1:1]};
    end
    if (ctrl.ofin) begin
      res_r <= res_nxt;
    end
  end

  assign value = rect_en ? signed'(res_r) : raw_r;

endmodule

`default_nettype wire

// ===== hdl/rectified_envelope_decimator_top.sv =====
// Rectifying envelope detector with decimated output for one or two channels.
// Each request is a sample tick carrying one signed sample per channel, or a
// restart that clears the previous rectified samples and reloads the
// decimation counter without producing a result. With rectify_enable set, a
// tick runs through the bit-serial multiplier (17 steps, one coefficient bit
// a cycle) and then the restoring divider (24 steps, one quotient bit a
// cycle), which runs a second time to scale the envelope by the channel
// factor for an emitted result. Restarts and pass-through ticks are taken in
// the idle state, which a pass-through tick leaves only for the emit state
// when it emits a result. Results sit in an output register, so a new request
// is taken while one still waits; the block only stalls when a second result
// is ready before the first has been taken. Configuration writes are always
// accepted and must only be made while the block is idle.
`default_nettype none

module rectified_envelope_decimator_top import red_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  red_in_if.sink    in_if,
  red_out_if.source out_if,
  red_cfg_if.sink   cfg_if
);

  // Control state
  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                emit_r;
  logic [PERIOD_W-1:0] samples_left_r, left_dec;
  logic                emit_tick;
  lane_ctrl_t          ctrl;
  logic                in_ready;
  logic                in_acc, cfg_acc;
  logic                load_out;

  // Shared configuration
  logic                rect_en_r;
  logic [PERIOD_W-1:0] period_r;

  // Output register
  logic    out_valid_r;
  sample_t out_a_r, out_b_r;
  sample_t lane_val [MAX_CHANNELS];

  assign in_acc       = in_if.valid && in_ready;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;
  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  assign left_dec  = samples_left_r - PERIOD_W'(1);
  assign emit_tick = (left_dec == '0);

  // Global registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_en_r <= RST_RECTIFY;
      period_r  <= RST_PERIOD;
    end else if (cfg_acc) begin
      case (cfg_if.index)
        REG_RECTIFY_ENABLE:    rect_en_r <= cfg_if.data[0];
        REG_DECIMATION_PERIOD: period_r  <= cfg_if.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel lanes with their own coefficient, factor and offset
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_ch
    if (c < NUM_CHANNELS) begin : g_lane
      localparam reg_idx_t COEF_IDX   = (c == 0) ? REG_COEF_A   : REG_COEF_B;
      localparam reg_idx_t FACTOR_IDX = (c == 0) ? REG_FACTOR_A : REG_FACTOR_B;
      localparam reg_idx_t OFFSET_IDX = (c == 0) ? REG_OFFSET_A : REG_OFFSET_B;

      logic [COEF_W-1:0]   coef_r;
      logic [FACTOR_W-1:0] factor_r;
      logic [OFFSET_W-1:0] offset_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          coef_r   <= RST_COEF;
          factor_r <= RST_FACTOR;
          offset_r <= RST_OFFSET;
        end else if (cfg_acc) begin
          if (cfg_if.index == COEF_IDX) begin
            coef_r <= cfg_if.data[COEF_W-1:0];
          end
          if (cfg_if.index == FACTOR_IDX) begin
            factor_r <= cfg_if.data[FACTOR_W-1:0];
          end
          if (cfg_if.index == OFFSET_IDX) begin
            offset_r <= cfg_if.data[OFFSET_W-1:0];
          end
        end
      end

      red_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rect_en (rect_en_r),
        .coef    (coef_r),
        .factor  (factor_r),
        .offset  (offset_r),
        .sample  ((c == 0) ? in_if.sample_a : in_if.sample_b),
        .value   (lane_val[c])
      );
    end else begin : g_unused
      // Unused channel reads as zero
      assign lane_val[c] = '0;
    end
  end

  // Sequencer: both lanes run in lockstep
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          ctrl.capture = 1'b1;
          if (in_if.command) begin
            ctrl.restart = 1'b1;
          end else if (rect_en_r) begin
            state_nxt = S_PREP;
          end else if (emit_tick) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_PREP: begin
        ctrl.prep = 1'b1;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        ctrl.mload = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        ctrl.mstep = 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          state_nxt = S_FLOAD;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_FLOAD: begin
        ctrl.fload = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_FDIV;
      end
      S_FDIV: begin
        ctrl.dstep = 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_UPD: begin
        ctrl.upd  = 1'b1;
        state_nxt = emit_r ? S_OLOAD : S_IDLE;
      end
      S_OLOAD: begin
        ctrl.oload = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_ODIV;
      end
      S_ODIV: begin
        ctrl.dstep = 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_OFIN;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_OFIN: begin
        ctrl.ofin = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Decimation counter: reload on restart and on every emitted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_left_r <= RST_PERIOD;
      emit_r         <= 1'b0;
    end else if (in_acc) begin
      if (in_if.command) begin
        samples_left_r <= period_r;
      end else begin
        samples_left_r <= emit_tick ? period_r : left_dec;
        emit_r         <= emit_tick;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_a_r <= lane_val[0];
      out_b_r <= lane_val[1];
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.value_a = out_a_r;
  assign out_if.value_b = out_b_r;

endmodule

`default_nettype wire

// ===== hdl/red_chk.sv =====
`default_nettype none

module red_chk import red_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    in_command,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire sample_t out_value_a,
  input wire sample_t out_value_b
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_a) && $stable(out_value_b))
    else $error("stalled result changed or dropped");

  // Drop nothing out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A restart request never makes a result
  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command && !out_valid |=> !out_valid)
    else $error("restart produced a result");

  // A new result is loaded only while the input side is held off
  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while accepting requests");

endmodule

bind rectified_envelope_decimator_top red_chk u_red_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_command  (in_if.command),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_value_a (out_if.value_a),
  .out_value_b (out_if.value_b)
);

`default_nettype wire
